>>> rtl/bdq_pkg.sv
// ---------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Word formats, operation and status codes and the cell control bundle.
// ---------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int CNT_W         = 4;
    localparam int KEY_W         = 32;
    localparam int SALARY_W      = 31;

    localparam logic [3:0] CAP_RESET = 4'd8;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_POP_FRONT  = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_LIST       = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]          op;
        logic [KEY_W-1:0]    record_key;
        logic [SALARY_W-1:0] record_salary;
    } request_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_W-1:0]    out_key;
        logic [SALARY_W-1:0] out_salary;
        logic [CNT_W-1:0]    entry_count;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [SALARY_W-1:0] salary;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_ROTATE,
        CELL_WRITE_TAIL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      at_tail;
        logic      at_free;
    } cell_ctrl_t;

endpackage

>>> rtl/bdq_cell.sv
// ---------------------------------------------------------------------------
// bdq_cell: one slot of the deque chain
// Holds one entry and takes the entry of a neighbour, the head or the push
// word as the shared command asks.
// ---------------------------------------------------------------------------
module bdq_cell
    import bdq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     left_data,
    input  entry_t     right_data,
    input  entry_t     head_data,
    input  entry_t     push_data,
    output entry_t     data
);

    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            CELL_HOLD:        data_next = data_reg;
            CELL_SHIFT_RIGHT: data_next = left_data;
            CELL_SHIFT_LEFT:  data_next = right_data;
            CELL_ROTATE:      data_next = ctrl.at_tail ? head_data : right_data;
            CELL_WRITE_TAIL:  data_next = ctrl.at_free ? push_data : data_reg;
            default:          data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/bounded_deque.sv
// ---------------------------------------------------------------------------
// bounded_deque: bounded double-ended queue of key and salary records
// A row of cells holds the entries, front in cell 0, shifting or rotating
// one place per cycle under a shared command.
// ---------------------------------------------------------------------------
//  channel   | handshake             | word
//  ----------+-----------------------+-----------------------------
//  request   | start high, busy low  | request_t (op, key, salary)
//  result    | result_valid strobe   | result_t, one cycle each
//  config    | cfg_valid, cfg_ready  | cfg_data, capacity limit
//
// A push or pop gives its result in the cycle after it is taken.
// A list reports the held entries in turn: the chain rotates by one place
// per cycle and cell 0 is reported, so busy stays high until the last is taken.
// Reset empties the queue and sets the limit to eight; entries need no
// clearing. Results cannot be held off by the receiver.
module bounded_deque
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  request_t   request,
    output logic       result_valid,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    localparam int CAP_MAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [3:0]       cap_reg;
    logic             valid_reg, valid_next;
    result_t          res_reg, res_next;

    cell_cmd_t        cmd;
    cell_ctrl_t       ctrl [DEPTH];
    entry_t           cell_data [DEPTH];
    entry_t           push_data;
    entry_t           head_data;
    entry_t           tail_data;
    logic [3:0]       limit;
    logic             list_step;

    assign push_data = '{key: request.record_key, salary: request.record_salary};
    assign head_data = cell_data[0];
    assign limit     = (cap_reg > 4'(CAP_MAX)) ? 4'(CAP_MAX) : cap_reg;
    assign list_step = (left_reg != '0);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t left_d;
            entry_t right_d;

            if (gi == 0)
            begin : g_first
                assign left_d = push_data;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            if (gi < MAX_RESULTS)
            begin : g_flags
                assign ctrl[gi] = '{cmd: cmd,
                                    at_tail: (count_reg == CNT_W'(gi + 1)),
                                    at_free: (count_reg == CNT_W'(gi))};
            end
            else
            begin : g_noflags
                assign ctrl[gi] = '{cmd: cmd, at_tail: 1'b0, at_free: 1'b0};
            end

            bdq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[gi]),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (head_data),
                .push_data  (push_data),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ctrl[i].at_tail)
            begin
                tail_data = tail_data | cell_data[i];
            end
        end
    end

    always_comb
    begin
        cmd        = CELL_HOLD;
        count_next = count_reg;
        left_next  = left_reg;
        valid_next = 1'b0;
        res_next   = res_reg;
        if (list_step)
        begin
            cmd        = CELL_ROTATE;
            left_next  = left_reg - 1'b1;
            valid_next = 1'b1;
            res_next   = '{ST_DONE, head_data.key, head_data.salary, count_reg,
                           (left_reg == CNT_W'(1))};
        end
        else if (start)
        begin
            unique case (request.op)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    valid_next = 1'b1;
                    if (count_reg >= limit)
                    begin
                        res_next = '{ST_FULL, '0, '0, count_reg, 1'b1};
                    end
                    else
                    begin
                        cmd = (request.op == OP_PUSH_FRONT) ? CELL_SHIFT_RIGHT
                                                            : CELL_WRITE_TAIL;
                        count_next = count_reg + 1'b1;
                        res_next   = '{ST_DONE, '0, '0, count_reg + 1'b1, 1'b1};
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        res_next = '{ST_EMPTY, '0, '0, count_reg, 1'b1};
                    end
                    else if (request.op == OP_POP_FRONT)
                    begin
                        cmd        = CELL_SHIFT_LEFT;
                        count_next = count_reg - 1'b1;
                        res_next   = '{ST_DONE, head_data.key, head_data.salary,
                                       count_reg - 1'b1, 1'b1};
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        res_next   = '{ST_DONE, tail_data.key, tail_data.salary,
                                       count_reg - 1'b1, 1'b1};
                    end
                end
                OP_LIST:
                begin
                    valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        res_next = '{ST_EMPTY, '0, '0, count_reg, 1'b1};
                    end
                    else
                    begin
                        cmd       = CELL_ROTATE;
                        left_next = count_reg - 1'b1;
                        res_next  = '{ST_DONE, head_data.key, head_data.salary,
                                      count_reg, (count_reg == CNT_W'(1))};
                    end
                end
                default:
                begin
                    valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            left_reg  <= '0;
            cap_reg   <= CAP_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            left_reg  <= left_next;
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy         = list_step;
    assign cfg_ready    = !list_step;
    assign result_valid = valid_reg;
    assign result       = res_reg;

    a_list_streams: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_valid)
        else $error("list step gave no result");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("non-final result without a pending list step");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.entry_count <= 4'(CAP_MAX)))
        else $error("entry count above the capacity bound");

endmodule
